/* rtl/radial_plasma_index_generator_core_defines.svh */
// Assertion macros shared by the plasma index generator RTL.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef RADIAL_PLASMA_INDEX_GENERATOR_CORE_DEFINES_SVH
`define RADIAL_PLASMA_INDEX_GENERATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RPIG_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define RPIG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define RPIG_ASSERT_ALWAYS(label, expr, msg)
`define RPIG_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

/* rtl/rpig_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rpig_pkg;

  localparam int COORD_BITS_DEFAULT = 10;
  localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;
  localparam int INDEX_BITS_DEFAULT = 13;

  localparam int CENTER_W = 24;
  localparam int RATE_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int DIFF_W = 13;
  localparam int SQUARE_W = 26;
  localparam int ROOT_IN_W = 34;
  localparam int ROOT_W = 17;
  localparam int PHASE_W = 16;
  localparam int FRAC_W = 14;
  localparam int SINE_W = 15;
  localparam int VALUE_W = 16;
  localparam int SUM_W = 18;
  localparam int NUM_W = 32;
  localparam int Q15_ONE = 32767;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd64;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

  // Series denominators (2k)*(2k+1) for k = 1 to 8.
  localparam logic [8:1][8:0] TAYLOR_DIV = {
    9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_ONE   = 3'd0,
    REG_CENTER_TWO   = 3'd1,
    REG_CENTER_THREE = 3'd2,
    REG_RATE_ONE     = 3'd3,
    REG_RATE_TWO     = 3'd4,
    REG_RATE_THREE   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center;
    logic [RATE_W-1:0]   rate;
  } source_cfg_t;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
  } lane_out_t;

  // Quarter-wave sine of a Q30 angle, rounded to unsigned Q15.
  function automatic logic [SINE_W-1:0] sine_q15(input longint unsigned x);
    longint signed sum;
    longint unsigned term;
    longint unsigned v;
    sum = longint'(x);
    term = x;
    for (int k = 1; k <= 8; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'(TAYLOR_DIV[k]);
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/rpig_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "radial_plasma_index_generator_core_defines.svh"
module rpig_sqrt #(
  parameter int IN_W = rpig_pkg::ROOT_IN_W,
  parameter int OUT_W = rpig_pkg::ROOT_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [IN_W-1:0]  in_value,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_root
);

  // One result bit per stage; the remainder and partial root ride along.
  logic [IN_W-1:0]  rem_q [OUT_W];
  logic [IN_W-1:0]  res_q [OUT_W];
  logic [OUT_W-1:0] valid_q;

  for (genvar j = 0; j < OUT_W; j++) begin : g_stage
    localparam logic [IN_W-1:0] BIT = IN_W'(1) << (2 * (OUT_W - 1 - j));
    logic [IN_W-1:0] rem_in;
    logic [IN_W-1:0] res_in;
    logic [IN_W-1:0] trial;
    logic            v_in;

    if (j == 0) begin : g_first
      assign rem_in = in_value;
      assign res_in = '0;
      assign v_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
      assign v_in = valid_q[j-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[j] <= 1'b0;
      end else begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_q[j] <= rem_in - trial;
        res_q[j] <= (res_in >> 1) + BIT;
      end else begin
        rem_q[j] <= rem_in;
        res_q[j] <= res_in >> 1;
      end
    end
  end

  assign out_valid = valid_q[OUT_W-1];
  assign out_root = res_q[OUT_W-1][OUT_W-1:0];

  `RPIG_ASSERT_IMPLY(a_sqrt_latency, in_valid, ##OUT_W out_valid, "sqrt item lost in pipeline")

endmodule
`default_nettype wire

/* rtl/rpig_source.sv */
`timescale 1ns / 1ps
`default_nettype none
module rpig_source #(
  parameter int COORD_BITS = rpig_pkg::COORD_BITS_DEFAULT,
  parameter int SINE_TABLE_DEPTH = rpig_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [COORD_BITS-1:0] px,
  input  wire logic [COORD_BITS-1:0] py,
  input  wire rpig_pkg::source_cfg_t cfg,
  output rpig_pkg::lane_out_t        lane_out
);

  localparam int AW = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
  localparam int PW = rpig_pkg::FRAC_W + AW + 1;
  localparam int DW = rpig_pkg::DIFF_W;
  localparam int MW = rpig_pkg::ROOT_W + rpig_pkg::RATE_W;

  logic [rpig_pkg::SINE_W-1:0] rom [SINE_TABLE_DEPTH];

  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam longint unsigned X =
      (rpig_pkg::Q30_HALF_PI * longint'(2 * i + 1)) / longint'(2 * SINE_TABLE_DEPTH);
    localparam logic [rpig_pkg::SINE_W-1:0] ROM_VAL = rpig_pkg::sine_q15(X);
    assign rom[i] = ROM_VAL;
  end

  logic                        v1, v2, v3, v_root, v_ph, v_ad, v_out;
  logic signed [DW-1:0]        dx, dy;
  logic [rpig_pkg::SQUARE_W-1:0] dx_sq, dy_sq;
  logic [rpig_pkg::ROOT_IN_W-1:0] root_in;
  logic [rpig_pkg::ROOT_W-1:0] dist_q4;
  logic [rpig_pkg::PHASE_W-1:0] phase;
  logic [AW-1:0]               addr;
  logic                        neg;
  logic signed [rpig_pkg::VALUE_W-1:0] value;

  logic signed [DW-1:0]        px_s, py_s, cx_s, cy_s;
  logic signed [2*DW-1:0]      dx_prod, dy_prod;
  logic [MW-1:0]               ph_prod;
  logic [PW-1:0]               addr_prod;
  logic [AW-1:0]               addr_raw;

  assign px_s = $signed(DW'(px));
  assign py_s = $signed(DW'(py));
  assign cx_s = $signed({cfg.center[23], cfg.center[23:12]});
  assign cy_s = $signed({cfg.center[11], cfg.center[11:0]});
  assign dx_prod = dx * dx;
  assign dy_prod = dy * dy;
  assign ph_prod = MW'(dist_q4) * MW'(cfg.rate);
  assign addr_prod = PW'(phase[rpig_pkg::FRAC_W-1:0]) * PW'(SINE_TABLE_DEPTH);
  assign addr_raw = addr_prod[rpig_pkg::FRAC_W +: AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v_ph <= 1'b0;
      v_ad <= 1'b0;
      v_out <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v_ph <= v_root;
      v_ad <= v_ph;
      v_out <= v_ad;
    end
  end

  always_ff @(posedge clk) begin
    dx <= px_s - cx_s;
    dy <= py_s - cy_s;
    dx_sq <= dx_prod[rpig_pkg::SQUARE_W-1:0];
    dy_sq <= dy_prod[rpig_pkg::SQUARE_W-1:0];
    // Distance comes out in Q.4, so the squared distance is scaled by 256.
    root_in <= {rpig_pkg::ROOT_IN_W'(dx_sq) + rpig_pkg::ROOT_IN_W'(dy_sq)} << 8;
    phase <= ph_prod[4 +: rpig_pkg::PHASE_W];
    // Odd quadrants run the quarter table backward, the lower half negates.
    if (phase[rpig_pkg::FRAC_W]) begin
      addr <= AW'(SINE_TABLE_DEPTH - 1) - addr_raw;
    end else begin
      addr <= addr_raw;
    end
    neg <= phase[rpig_pkg::FRAC_W+1];
    if (neg) begin
      value <= -$signed({1'b0, rom[addr]});
    end else begin
      value <= $signed({1'b0, rom[addr]});
    end
  end

  rpig_sqrt #(
    .IN_W (rpig_pkg::ROOT_IN_W),
    .OUT_W(rpig_pkg::ROOT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .in_value (root_in),
    .out_valid(v_root),
    .out_root (dist_q4)
  );

  assign lane_out.valid = v_out;
  assign lane_out.value = value;

endmodule
`default_nettype wire

/* rtl/rpig_combine.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "radial_plasma_index_generator_core_defines.svh"
module rpig_combine #(
  parameter int INDEX_BITS = rpig_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                rst,
  input  wire logic                clk,
  input  wire rpig_pkg::lane_out_t lane_a,
  input  wire rpig_pkg::lane_out_t lane_b,
  input  wire rpig_pkg::lane_out_t lane_c,
  output logic                     done,
  output logic [INDEX_BITS-1:0]    index
);

  localparam int CENTRE = 1 << (INDEX_BITS - 1);
  localparam int SCALE = (CENTRE - 1) / 3;
  localparam int TOP = (1 << INDEX_BITS) - 1;
  localparam int NW = rpig_pkg::NUM_W;
  localparam int SW = rpig_pkg::SUM_W;
  localparam logic signed [NW-1:0] SCALE_S = NW'(SCALE);
  localparam logic signed [NW-1:0] OFFSET_S = NW'(CENTRE * rpig_pkg::Q15_ONE);

  logic                 v_sum, v_num, v_div;
  logic signed [SW-1:0] sum;
  logic signed [NW-1:0] num;
  logic [15:0]          quot;
  logic                 carry;
  logic [15:0]          q0;
  logic [16:0]          rem;
  logic [16:0]          quot_full;

  // Divide by 2^15-1: the remainder after a shift is the low bits plus the
  // high part, and stays below twice the divisor.
  assign q0 = num[NW-1] ? 16'd0 : num[30:15];
  assign rem = num[NW-1] ? 17'd0 : (17'(num[14:0]) + 17'(q0));
  assign quot_full = 17'(quot) + 17'(carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sum <= 1'b0;
      v_num <= 1'b0;
      v_div <= 1'b0;
      done <= 1'b0;
    end else begin
      v_sum <= lane_a.valid;
      v_num <= v_sum;
      v_div <= v_num;
      done <= v_div;
    end
  end

  always_ff @(posedge clk) begin
    sum <= SW'(lane_a.value) + SW'(lane_b.value) + SW'(lane_c.value);
    num <= NW'(sum) * SCALE_S + OFFSET_S;
    quot <= q0;
    carry <= (rem >= 17'(rpig_pkg::Q15_ONE));
    if (quot_full > 17'(TOP)) begin
      index <= INDEX_BITS'(TOP);
    end else begin
      index <= quot_full[INDEX_BITS-1:0];
    end
  end

  `RPIG_ASSERT_IMPLY(a_combine_latency, lane_a.valid, ##4 done, "combine item lost")
  `RPIG_ASSERT_IMPLY(a_combine_lanes, lane_a.valid, lane_b.valid && lane_c.valid, "lanes out of step")

endmodule
`default_nettype wire

/* rtl/radial_plasma_index_generator_core.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "radial_plasma_index_generator_core_defines.svh"
// Plasma palette index generator: one pixel coordinate in, one palette index out.
// Input: a pixel (pixel_x, pixel_y) is taken at a rising edge where start is high
// and busy is low. busy stays low, so a pixel may be presented on every cycle.
// Output: palette_index is valid for the single cycle in which done is high; the
// receiver has no way to stall, and every item appears exactly once, in order.
// Pipeline: the input register, then the three source lanes in parallel, then the
// combiner. Throughput is one item per cycle. The bulk of the pipeline is the
// square root, which resolves one result bit per pipeline stage (17 stages).
// Configuration: registers 0 to 2 hold the three source centers (x in 23:12, y in
// 11:0, two's complement), registers 3 to 5 the phase rates. cfg_ready is always
// high; writes to unlisted indexes are dropped. Write only while no items are in
// flight.
// Reset: synchronous; clears the pipeline valid bits, sets centers to zero and
// rates to 64. No warm-up is needed after reset.
module radial_plasma_index_generator_core #(
  parameter int COORD_BITS = rpig_pkg::COORD_BITS_DEFAULT,
  parameter int SINE_TABLE_DEPTH = rpig_pkg::SINE_TABLE_DEPTH_DEFAULT,
  parameter int INDEX_BITS = rpig_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [COORD_BITS-1:0]               pixel_x,
  input  wire logic [COORD_BITS-1:0]               pixel_y,
  output logic                                     done,
  output logic [INDEX_BITS-1:0]                    palette_index,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rpig_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [rpig_pkg::CENTER_W-1:0]       cfg_data
);

  logic [rpig_pkg::CENTER_W-1:0] center_one, center_two, center_three;
  logic [rpig_pkg::RATE_W-1:0]   rate_one, rate_two, rate_three;
  logic                          in_valid;
  logic [COORD_BITS-1:0]         px, py;
  rpig_pkg::source_cfg_t         cfg_a, cfg_b, cfg_c;
  rpig_pkg::lane_out_t           lane_a, lane_b, lane_c;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_one <= '0;
      center_two <= '0;
      center_three <= '0;
      rate_one <= rpig_pkg::RATE_RESET;
      rate_two <= rpig_pkg::RATE_RESET;
      rate_three <= rpig_pkg::RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rpig_pkg::REG_CENTER_ONE: center_one <= cfg_data;
        rpig_pkg::REG_CENTER_TWO: center_two <= cfg_data;
        rpig_pkg::REG_CENTER_THREE: center_three <= cfg_data;
        rpig_pkg::REG_RATE_ONE: rate_one <= cfg_data[rpig_pkg::RATE_W-1:0];
        rpig_pkg::REG_RATE_TWO: rate_two <= cfg_data[rpig_pkg::RATE_W-1:0];
        rpig_pkg::REG_RATE_THREE: rate_three <= cfg_data[rpig_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    px <= pixel_x;
    py <= pixel_y;
  end

  assign cfg_a = '{center: center_one, rate: rate_one};
  assign cfg_b = '{center: center_two, rate: rate_two};
  assign cfg_c = '{center: center_three, rate: rate_three};

  rpig_source #(.COORD_BITS(COORD_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_src_a (
    .clk(clk), .rst(rst), .in_valid(in_valid), .px(px), .py(py), .cfg(cfg_a),
    .lane_out(lane_a)
  );

  rpig_source #(.COORD_BITS(COORD_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_src_b (
    .clk(clk), .rst(rst), .in_valid(in_valid), .px(px), .py(py), .cfg(cfg_b),
    .lane_out(lane_b)
  );

  rpig_source #(.COORD_BITS(COORD_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_src_c (
    .clk(clk), .rst(rst), .in_valid(in_valid), .px(px), .py(py), .cfg(cfg_c),
    .lane_out(lane_c)
  );

  rpig_combine #(.INDEX_BITS(INDEX_BITS)) u_combine (
    .rst   (rst),
    .clk   (clk),
    .lane_a(lane_a),
    .lane_b(lane_b),
    .lane_c(lane_c),
    .done  (done),
    .index (palette_index)
  );

  `RPIG_ASSERT_ALWAYS(a_lanes_agree, (lane_a.valid == lane_b.valid) && (lane_b.valid == lane_c.valid), "lane valid mismatch")

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  localparam int DEPTH = rpig_pkg::SINE_TABLE_DEPTH_DEFAULT;
  localparam int LATENCY = 28;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [rpig_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LOW = 3'd6;
  localparam logic [rpig_pkg::CFG_INDEX_W-1:0] REG_UNUSED_HIGH = 3'd7;

  typedef struct {
    logic [9:0]  x;
    logic [9:0]  y;
    bit          typed;
    logic [12:0] index;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [9:0] pixel_x = '0;
  logic [9:0] pixel_y = '0;
  logic cfg_valid = 1'b0;
  logic [rpig_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rpig_pkg::CENTER_W-1:0] cfg_data = '0;
  logic busy, done, cfg_ready;
  logic [12:0] palette_index;

  radial_plasma_index_generator_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .done(done),
    .palette_index(palette_index), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [rpig_pkg::SINE_W-1:0] quarter_sine[DEPTH];
  logic [rpig_pkg::CENTER_W-1:0] src_center[3];
  logic [rpig_pkg::RATE_W-1:0] src_rate[3];
  logic [12:0] pending_index[$];
  int mismatches = 0;
  int cycles = 0;
  pixel_row_t pixel_table[$];
  // When set, the item being driven is checked against a typed-in value.
  bit cur_typed = 1'b0;
  logic [12:0] cur_index = '0;

  function automatic longint unsigned sine_q30_series(longint unsigned x);
    longint signed acc;
    longint unsigned t;
    acc = longint'(x);
    t = x;
    for (int k = 1; k <= 8; k++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc -= longint'(t);
      else acc += longint'(t);
    end
    if (acc < 0) acc = 0;
    return longint'(acc);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint signed source_wave(int s, logic [9:0] px, logic [9:0] py);
    logic signed [11:0] cx, cy;
    longint signed dx, dy;
    longint unsigned dist_q4, phase, addr;
    cx = src_center[s][23:12];
    cy = src_center[s][11:0];
    dx = longint'(px) - longint'(cx);
    dy = longint'(py) - longint'(cy);
    dist_q4 = floor_root(longint'(dx * dx + dy * dy) << 8);
    phase = ((dist_q4 * src_rate[s]) >> 4) & 64'hFFFF;
    addr = ((phase & 64'h3FFF) * DEPTH) >> 14;
    if (addr >= DEPTH) addr = DEPTH - 1;
    if (phase[14]) addr = DEPTH - 1 - addr;
    return phase[15] ? -longint'(quarter_sine[addr]) : longint'(quarter_sine[addr]);
  endfunction

  function automatic logic [12:0] plasma_index(logic [9:0] px, logic [9:0] py);
    longint signed total, num;
    total = source_wave(0, px, py) + source_wave(1, px, py) + source_wave(2, px, py);
    num = total * 1365 + 4096 * rpig_pkg::Q15_ONE;
    if (num < 0) num = 0;
    num = num / rpig_pkg::Q15_ONE;
    if (num > 8191) num = 8191;
    return num[12:0];
  endfunction

  initial begin
    longint unsigned v;
    for (int i = 0; i < DEPTH; i++) begin
      v = (rpig_pkg::Q30_HALF_PI * (2 * i + 1)) / (2 * DEPTH);
      v = (sine_q30_series(v) * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      quarter_sine[i] = v[rpig_pkg::SINE_W-1:0];
    end
    for (int s = 0; s < 3; s++) begin
      src_center[s] = '0;
      src_rate[s] = rpig_pkg::RATE_RESET;
    end
  end

  // Scoreboard: every accepted pixel gets its expected index (typed-in or predicted) queued at the accepting edge.
  always @(posedge clk) begin
    logic [12:0] want;
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) begin
        if (cur_typed) pending_index.push_back(cur_index);
        else pending_index.push_back(plasma_index(pixel_x, pixel_y));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rpig_pkg::REG_CENTER_ONE:   src_center[0] = cfg_data;
          rpig_pkg::REG_CENTER_TWO:   src_center[1] = cfg_data;
          rpig_pkg::REG_CENTER_THREE: src_center[2] = cfg_data;
          rpig_pkg::REG_RATE_ONE:     src_rate[0] = cfg_data[15:0];
          rpig_pkg::REG_RATE_TWO:     src_rate[1] = cfg_data[15:0];
          rpig_pkg::REG_RATE_THREE:   src_rate[2] = cfg_data[15:0];
          default: ;
        endcase
      end
      if (done) begin
        if (pending_index.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: index %0d", palette_index);
        end else begin
          want = pending_index.pop_front();
          if (palette_index !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("index mismatch: expected %0d got %0d", want, palette_index);
          end
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("[radial_plasma_index_generator_core] ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Leaves valid high so that writes can follow back to back; the caller drops it.
  task automatic write_reg(logic [rpig_pkg::CFG_INDEX_W-1:0] idx,
                           logic [rpig_pkg::CENTER_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Only touch registers once the pipeline has drained.
  task automatic drain();
    while (pending_index.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic load_sources(logic [23:0] c0, c1, c2, logic [15:0] r0, r1, r2);
    drain();
    write_reg(rpig_pkg::REG_CENTER_ONE, c0);
    write_reg(rpig_pkg::REG_CENTER_TWO, c1);
    write_reg(rpig_pkg::REG_CENTER_THREE, c2);
    write_reg(rpig_pkg::REG_RATE_ONE, {8'($urandom_range(0, 255)), r0});
    write_reg(rpig_pkg::REG_RATE_TWO, {8'($urandom_range(0, 255)), r1});
    write_reg(rpig_pkg::REG_RATE_THREE, {8'($urandom_range(0, 255)), r2});
    cfg_valid <= 1'b0;
  endtask

  // Drives one pixel; start stays high into the next item when there is no gap.
  task automatic send_pixel(logic [9:0] x, logic [9:0] y);
    int g;
    start <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      pixel_x <= 10'($urandom);
      pixel_y <= 10'($urandom);
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic run_table();
    foreach (pixel_table[i]) send_pixel(pixel_table[i].x, pixel_table[i].y);
    start <= 1'b0;
  endtask

  task automatic random_burst(int n);
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 2) send_pixel(mode == 0 ? 10'd0 : 10'd1023, 10'($urandom));
      else send_pixel(10'($urandom), 10'($urandom));
    end
    start <= 1'b0;
  endtask

  initial begin
    pixel_table.push_back('{10'd0, 10'd0, 1'b1, 13'd4099});
    pixel_table.push_back('{10'd1023, 10'd1023, 1'b0, '0});
    pixel_table.push_back('{10'd0, 10'd1023, 1'b0, '0});
    pixel_table.push_back('{10'd1023, 10'd0, 1'b0, '0});
    pixel_table.push_back('{10'd512, 10'd512, 1'b0, '0});
    pixel_table.push_back('{10'd511, 10'd511, 1'b0, '0});
    pixel_table.push_back('{10'd1, 10'd0, 1'b0, '0});
    pixel_table.push_back('{10'd0, 10'd1, 1'b0, '0});
    pixel_table.push_back('{10'd341, 10'd682, 1'b0, '0});
    pixel_table.push_back('{10'd682, 10'd341, 1'b0, '0});

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Fixed expectation straight after reset: all three sources sit at the origin.
    @(negedge clk);
    cur_typed = pixel_table[0].typed;
    cur_index = pixel_table[0].index;
    send_pixel(pixel_table[0].x, pixel_table[0].y);
    start <= 1'b0;
    cur_typed = 1'b0;
    @(negedge clk);
    drain();
    run_table();

    // Bad register indexes must be dropped without touching any source.
    drain();
    write_reg(REG_UNUSED_LOW, 24'hFFFFFF);
    write_reg(REG_UNUSED_HIGH, 24'h123456);
    cfg_valid <= 1'b0;
    run_table();

    load_sources(24'h800800, 24'h7FF7FF, 24'h8007FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_table();
    load_sources(24'h7FF800, 24'h000000, 24'hFFFFFF, 16'h0000, 16'h0000, 16'h0000);
    run_table();
    load_sources(24'h200200, 24'h100300, 24'h3FF000, 16'h0001, 16'h8000, 16'h1234);
    random_burst(40);

    for (int p = 0; p < 9; p++) begin
      load_sources(24'($urandom), 24'($urandom), 24'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom_range(0, 1024)));
      random_burst(40);
    end

    drain();
    if (mismatches == 0 && pending_index.size() == 0)
      $display("[radial_plasma_index_generator_core] OK");
    else
      $display("[radial_plasma_index_generator_core] ERROR");
    $finish;
  end
endmodule

/* radial_plasma_index_generator_core.f */
+incdir+rtl
rtl/rpig_pkg.sv
rtl/rpig_sqrt.sv
rtl/rpig_source.sv
rtl/rpig_combine.sv
rtl/radial_plasma_index_generator_core.sv
sim/tb_top.sv
